// ===== rtl/core/dtlv_pkg.sv =====
// ----------------------------------------------------------------------------
// dtlv_pkg
// Shared types and constants for the DHCP options TLV parser core.
// ----------------------------------------------------------------------------
package dtlv_pkg;

  // option codes
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_SUBNET   = 8'd1;
  localparam logic [7:0] OPT_ROUTER   = 8'd3;
  localparam logic [7:0] OPT_DNS      = 8'd6;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;

  // bytes kept from an address option
  localparam logic [2:0] ADDR_BYTES   = 3'd4;

  // walker phases
  localparam logic [1:0] PH_CODE  = 2'd0;
  localparam logic [1:0] PH_LEN   = 2'd1;
  localparam logic [1:0] PH_VALUE = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // parse status codes
  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_TRUNCATED = 1'b1;

  // one input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [7:0]  msg_type;
    logic [31:0] subnet_mask;
    logic [31:0] gateway_addr;
    logic [31:0] dns_addr;
    logic        has_subnet;
    logic        has_gateway;
    logic        has_dns;
    logic        parse_status;
  } result_t;

endpackage

// ===== rtl/core/dtlv_walker.sv =====
// ----------------------------------------------------------------------------
// dtlv_walker
// TLV walk state: takes one byte per fire and presents the summary of the
// area, including the current byte, for use on the last byte.
// ----------------------------------------------------------------------------
module dtlv_walker (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  dtlv_pkg::in_beat_t beat,
  output dtlv_pkg::result_t res
);
  import dtlv_pkg::*;

  logic [1:0]  phase, phase_next;
  logic [7:0]  cur_code, cur_code_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [7:0]  opt_length, opt_length_next;
  logic [31:0] value_shift, value_shift_next;
  logic [2:0]  value_count, value_count_next;
  logic [7:0]  held_msg_type, held_msg_type_next;
  logic [31:0] held_subnet, held_subnet_next;
  logic [31:0] held_gateway, held_gateway_next;
  logic [31:0] held_dns, held_dns_next;
  logic [2:0]  held_flags, held_flags_next;
  logic [7:0]  b;

  assign b = beat.data_byte;

  // next state for one byte
  always_comb begin
    phase_next         = phase;
    cur_code_next      = cur_code;
    bytes_left_next    = bytes_left;
    opt_length_next    = opt_length;
    value_shift_next   = value_shift;
    value_count_next   = value_count;
    held_msg_type_next = held_msg_type;
    held_subnet_next   = held_subnet;
    held_gateway_next  = held_gateway;
    held_dns_next      = held_dns;
    held_flags_next    = held_flags;
    if (fire) begin
      case (phase)
        PH_CODE: begin
          if (b == OPT_END) begin
            phase_next = PH_DONE;
          end else if (b != OPT_PAD) begin
            cur_code_next = b;
            phase_next    = PH_LEN;
          end
        end
        PH_LEN: begin
          // a zero-length option ends here and commits nothing
          opt_length_next  = b;
          bytes_left_next  = b;
          value_shift_next = '0;
          value_count_next = '0;
          phase_next       = (b == 8'd0) ? PH_CODE : PH_VALUE;
        end
        PH_VALUE: begin
          // little-endian capture of the first four value bytes
          if (value_count < ADDR_BYTES) begin
            case (value_count[1:0])
              2'd0:    value_shift_next[7:0]   = b;
              2'd1:    value_shift_next[15:8]  = b;
              2'd2:    value_shift_next[23:16] = b;
              default: value_shift_next[31:24] = b;
            endcase
            value_count_next = value_count + 3'd1;
          end
          bytes_left_next = bytes_left - 8'd1;
          // commit once the whole value is in
          if (bytes_left_next == 8'd0) begin
            phase_next = PH_CODE;
            if (cur_code == OPT_MSG_TYPE) begin
              held_msg_type_next = value_shift_next[7:0];
            end else if (opt_length >= {5'd0, ADDR_BYTES}) begin
              if (cur_code == OPT_SUBNET) begin
                held_subnet_next   = value_shift_next;
                held_flags_next[0] = 1'b1;
              end else if (cur_code == OPT_ROUTER) begin
                held_gateway_next  = value_shift_next;
                held_flags_next[1] = 1'b1;
              end else if (cur_code == OPT_DNS) begin
                held_dns_next      = value_shift_next;
                held_flags_next[2] = 1'b1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // summary as it stands after this byte
  always_comb begin
    res.msg_type     = held_msg_type_next;
    res.subnet_mask  = held_subnet_next;
    res.gateway_addr = held_gateway_next;
    res.dns_addr     = held_dns_next;
    res.has_subnet   = held_flags_next[0];
    res.has_gateway  = held_flags_next[1];
    res.has_dns      = held_flags_next[2];
    res.parse_status = (phase_next == PH_LEN || phase_next == PH_VALUE) ?
                       STATUS_TRUNCATED : STATUS_OK;
  end

  // state registers, cleared after the last byte of each area
  always_ff @(posedge clk) begin
    if (rst || (fire && beat.last_byte)) begin
      phase         <= PH_CODE;
      cur_code      <= '0;
      bytes_left    <= '0;
      opt_length    <= '0;
      value_shift   <= '0;
      value_count   <= '0;
      held_msg_type <= '0;
      held_subnet   <= '0;
      held_gateway  <= '0;
      held_dns      <= '0;
      held_flags    <= '0;
    end else if (fire) begin
      phase         <= phase_next;
      cur_code      <= cur_code_next;
      bytes_left    <= bytes_left_next;
      opt_length    <= opt_length_next;
      value_shift   <= value_shift_next;
      value_count   <= value_count_next;
      held_msg_type <= held_msg_type_next;
      held_subnet   <= held_subnet_next;
      held_gateway  <= held_gateway_next;
      held_dns      <= held_dns_next;
      held_flags    <= held_flags_next;
    end
  end

  // capture count never runs past four bytes
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    value_count <= ADDR_BYTES)
    else $error("value capture count overflow");

  // after the last byte the walk starts over
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && beat.last_byte) |=> (phase == PH_CODE && held_flags == 3'd0))
    else $error("walker did not restart after last byte");

  // the value phase always has bytes left to take
  a_value_left: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_VALUE) |-> (bytes_left != 8'd0))
    else $error("value phase with no bytes left");

endmodule

// ===== rtl/core/dhcp_option_tlv_parser_core.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_core
// DHCP options TLV parser: one options byte per beat in, one summary out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry the options area one byte per beat, with
//   last_byte set on the final byte. A beat moves on an edge where valid is
//   high and stall is low.
//   out_valid/out_stall/out_data carry one summary beat per area, produced
//   from the byte that carries last_byte.
// Path: a byte is held in the input register and walked from there; the
//   summary of an area is registered in the output register when its last
//   byte is walked, and moves out when out_stall is low.
// Throughput: one byte per cycle while in_stall is low, set by the walker update.
// Stall: a finished summary waits in the output register while bytes keep
//   flowing in. Only a further last byte waits in the input register, and
//   in_stall rises, while the previous summary is still stalled.
// Reset: rst is synchronous, active high; it empties both registers and
//   returns the walker to the start of an area.
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtlv_pkg::in_beat_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtlv_pkg::result_t  out_data
);
  import dtlv_pkg::*;

  logic     in_reg_valid;
  in_beat_t in_reg;
  logic     advance;
  logic     in_fire;
  logic     out_free;
  result_t  walk_res;

  // output register can take a new summary this cycle
  assign out_free = !out_valid || !out_stall;
  // held byte proceeds unless it would produce a summary with nowhere to go
  assign advance  = in_reg_valid && (!in_reg.last_byte || out_free);
  assign in_stall = in_reg_valid && !advance;
  assign in_fire  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_fire) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_reg <= in_data;
    end
  end

  dtlv_walker u_walker (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .beat (in_reg),
    .res  (walk_res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && in_reg.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_reg.last_byte) begin
      out_data <= walk_res;
    end
  end

  // a last byte never overwrites a summary that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall && in_reg_valid && in_reg.last_byte) |-> in_stall)
    else $error("summary overwritten while stalled");

  // walking a last byte always yields a summary beat
  a_summary_out: assert property (@(posedge clk) disable iff (rst)
    (advance && in_reg.last_byte) |=> out_valid)
    else $error("missing summary after last byte");

  // input only stalls on a held last byte
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (in_reg_valid && in_reg.last_byte && out_valid && out_stall))
    else $error("input stalled without cause");

endmodule

// ===== test/dhcp_option_tlv_parser_core_test.sv =====
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser_core_test
// Self-checking bench for the DHCP options TLV parser. Options areas are sent
// one byte per beat. A walker kept inside the bench tracks the parse and
// queues the summary expected on each last byte. Every summary coming out is
// compared field by field with the oldest queued one. Both sides idle in
// random bursts, except in the final full-rate part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dhcp_option_tlv_parser_core_test;
  import dtlv_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BYTES = 1000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  in_beat_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  result_t  out_data;

  // bench controls and counters
  logic     idle_en = 1'b1;
  int       error_cnt = 0;
  int       cycle_cnt = 0;
  int       bytes_sent = 0;
  int       stall_left = 0;
  result_t  summary_q[$];
  result_t  want_sum;

  // expected walker state
  logic [1:0]  walk_phase;
  logic [7:0]  opt_code;
  logic [7:0]  opt_len;
  logic [7:0]  remain;
  logic [31:0] acc_word;
  logic [2:0]  acc_cnt;
  logic [7:0]  kept_type;
  logic [31:0] kept_mask;
  logic [31:0] kept_gw;
  logic [31:0] kept_dns;
  logic [2:0]  kept_flags;

  dhcp_option_tlv_parser_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // walker back to the start of an area
  function automatic void clear_walker();
    walk_phase = PH_CODE;
    opt_code   = '0;
    opt_len    = '0;
    remain     = '0;
    acc_word   = '0;
    acc_cnt    = '0;
    kept_type  = '0;
    kept_mask  = '0;
    kept_gw    = '0;
    kept_dns   = '0;
    kept_flags = '0;
  endfunction

  // keep a finished option if it is one we track and long enough
  function automatic void store_option();
    if (opt_code == OPT_MSG_TYPE && opt_len >= 8'd1) begin
      kept_type = acc_word[7:0];
    end else if (opt_code == OPT_SUBNET && opt_len >= {5'd0, ADDR_BYTES}) begin
      kept_mask = acc_word;
      kept_flags[0] = 1'b1;
    end else if (opt_code == OPT_ROUTER && opt_len >= {5'd0, ADDR_BYTES}) begin
      kept_gw = acc_word;
      kept_flags[1] = 1'b1;
    end else if (opt_code == OPT_DNS && opt_len >= {5'd0, ADDR_BYTES}) begin
      kept_dns = acc_word;
      kept_flags[2] = 1'b1;
    end
  endfunction

  // advance the walker by one accepted byte, queue a summary on the last one
  task automatic predict_byte(input in_beat_t beat);
    result_t sum;
    case (walk_phase)
      PH_CODE: begin
        if (beat.data_byte == OPT_END) begin
          walk_phase = PH_DONE;
        end else if (beat.data_byte != OPT_PAD) begin
          opt_code   = beat.data_byte;
          walk_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        opt_len  = beat.data_byte;
        remain   = beat.data_byte;
        acc_word = '0;
        acc_cnt  = '0;
        if (beat.data_byte == 8'd0) begin
          store_option();
          walk_phase = PH_CODE;
        end else begin
          walk_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (acc_cnt < ADDR_BYTES) begin
          acc_word = acc_word | (32'(beat.data_byte) << (8 * acc_cnt));
          acc_cnt  = acc_cnt + 3'd1;
        end
        remain = remain - 8'd1;
        if (remain == 8'd0) begin
          store_option();
          walk_phase = PH_CODE;
        end
      end
      default: begin
      end
    endcase
    if (beat.last_byte) begin
      sum.msg_type     = kept_type;
      sum.subnet_mask  = kept_mask;
      sum.gateway_addr = kept_gw;
      sum.dns_addr     = kept_dns;
      sum.has_subnet   = kept_flags[0];
      sum.has_gateway  = kept_flags[1];
      sum.has_dns      = kept_flags[2];
      sum.parse_status = (walk_phase == PH_LEN || walk_phase == PH_VALUE) ?
                         STATUS_TRUNCATED : STATUS_OK;
      summary_q.push_back(sum);
      clear_walker();
    end
  endtask

  // drive one byte beat, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic last);
    in_beat_t beat;
    int       gap;
    beat.data_byte = b;
    beat.last_byte = last;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(beat);
    bytes_sent++;
  endtask

  // send a whole area, last_byte on its final byte
  task automatic send_area(input logic [7:0] area[$]);
    for (int k = 0; k < area.size(); k++) begin
      send_byte(area[k], k == area.size() - 1);
    end
  endtask

  // wait until every queued summary has come out, then a little longer
  task automatic wait_drain();
    while (summary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one random area: mostly well formed, some cut short, some plain noise
  task automatic send_random_area();
    logic [7:0] area[$];
    logic [7:0] code;
    int         n_opt;
    int         len;
    int         mode;
    int         cut;
    n_opt = $urandom_range(0, 5);
    for (int i = 0; i < n_opt; i++) begin
      case ($urandom_range(0, 11))
        0: begin
          area.push_back(OPT_PAD);
          continue;
        end
        1, 2: begin
          code = OPT_MSG_TYPE;
          len  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 1;
        end
        3, 4: begin
          code = OPT_SUBNET;
          len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
        end
        5, 6: begin
          code = OPT_ROUTER;
          len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
        end
        7, 8: begin
          code = OPT_DNS;
          len  = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 4;
        end
        9, 10: begin
          code = 8'($urandom_range(0, 255));
          len  = ($urandom_range(0, 63) == 0) ? 255 : $urandom_range(0, 6);
        end
        default: begin
          area.push_back(OPT_END);
          continue;
        end
      endcase
      area.push_back(code);
      area.push_back(len[7:0]);
      repeat (len) area.push_back(8'($urandom_range(0, 255)));
    end
    mode = $urandom_range(0, 9);
    if (mode >= 7 && mode <= 8 && area.size() > 1) begin
      cut = $urandom_range(1, area.size() - 1);
      while (area.size() > cut) void'(area.pop_back());
    end else if (mode == 9) begin
      area.delete();
      repeat ($urandom_range(1, 10)) area.push_back(8'($urandom_range(0, 255)));
    end
    if (area.size() == 0) area.push_back(8'($urandom_range(0, 255)));
    send_area(area);
  endtask

  // pad, message type at the top value, subnet with extreme bytes, end, trailer
  task automatic test_pad_end_trailing();
    logic [7:0] area[$];
    area = '{OPT_PAD, OPT_MSG_TYPE, 8'd1, 8'hFF,
             OPT_SUBNET, 8'd4, 8'h00, 8'hFF, 8'h80, 8'h01,
             OPT_END, 8'hAA};
    send_area(area);
  endtask

  // empty router, short dns ending exactly on the last byte
  task automatic test_short_and_empty();
    logic [7:0] area[$];
    area = '{OPT_ROUTER, 8'd0, OPT_DNS, 8'd3, 8'h01, 8'h02, 8'h03};
    send_area(area);
  endtask

  // missing length, unfinished value, and a lone pad as the last byte
  task automatic test_truncation();
    logic [7:0] area[$];
    area = '{8'h07};
    send_area(area);
    area = '{OPT_ROUTER, 8'd4, 8'h09};
    send_area(area);
    area = '{OPT_PAD};
    send_area(area);
  endtask

  // random areas with idle bursts on both sides
  task automatic test_random_idle(input int target);
    while (bytes_sent < target) send_random_area();
  endtask

  // sender holds off until every summary has come out
  task automatic test_pressure();
    repeat (3) send_random_area();
    in_valid <= 1'b0;
    wait_drain();
  endtask

  // random areas at full rate, no idling anywhere
  task automatic test_random_full_rate(input int target);
    idle_en = 1'b0;
    while (bytes_sent < target) send_random_area();
  endtask

  // compare one field of a summary
  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
      error_cnt++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        $display("%0t: unexpected summary, expected none, actual %h", $time, out_data);
        error_cnt++;
      end else begin
        want_sum = summary_q.pop_front();
        check_field("msg_type", 32'(want_sum.msg_type), 32'(out_data.msg_type));
        check_field("subnet_mask", want_sum.subnet_mask, out_data.subnet_mask);
        check_field("gateway_addr", want_sum.gateway_addr, out_data.gateway_addr);
        check_field("dns_addr", want_sum.dns_addr, out_data.dns_addr);
        check_field("has_subnet", 32'(want_sum.has_subnet), 32'(out_data.has_subnet));
        check_field("has_gateway", 32'(want_sum.has_gateway), 32'(out_data.has_gateway));
        check_field("has_dns", 32'(want_sum.has_dns), 32'(out_data.has_dns));
        check_field("parse_status", 32'(want_sum.parse_status), 32'(out_data.parse_status));
      end
    end
  end

  // receiver stalls at random, in bursts
  always @(posedge clk) begin
    if (rst || !idle_en) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= ($urandom_range(0, 2) == 0);
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // test sequence
  initial begin
    clear_walker();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_pad_end_trailing();
    test_short_and_empty();
    test_truncation();
    test_random_idle(RANDOM_BYTES / 2);
    test_pressure();
    test_random_idle(RANDOM_BYTES * 3 / 4);
    test_random_full_rate(RANDOM_BYTES);
    in_valid <= 1'b0;
    wait_drain();
    if (error_cnt == 0 && summary_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
